>>> rtl/core/nsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsp_pkg: shared types and constants for the oscillator peak-response core
// Payload structs, configuration register indexes and sequencer states.
// ----------------------------------------------------------------------------
package nsp_pkg;

	localparam int DEF_WORD_BITS = 48;
	localparam int DEF_FRAC_BITS = 24;
	localparam int CFG_BITS      = 47;
	localparam int IN_BITS       = 48;
	localparam int OUT_BITS      = 47;
	localparam int IDX_BITS      = 3;
	localparam int DIGIT_BITS    = 4;

	localparam logic [IDX_BITS-1:0] REG_STIFFNESS = 3'd0;
	localparam logic [IDX_BITS-1:0] REG_DAMPING   = 3'd1;
	localparam logic [IDX_BITS-1:0] REG_INV_K_HAT = 3'd2;
	localparam logic [IDX_BITS-1:0] REG_TWO_DT    = 3'd3;
	localparam logic [IDX_BITS-1:0] REG_FOUR_DT2  = 3'd4;
	localparam logic [IDX_BITS-1:0] REG_SA_SCALE  = 3'd5;

	typedef struct packed {
		logic signed [IN_BITS-1:0] accel_sample;
		logic                      first_sample;
	} nsp_in_t;

	typedef struct packed {
		logic [OUT_BITS-1:0] peak_disp;
		logic [OUT_BITS-1:0] spectral_accel;
	} nsp_out_t;

	typedef struct packed {
		logic [IDX_BITS-1:0] index;
		logic [CFG_BITS-1:0] data;
	} nsp_cfg_t;

	// Sequencer steps, one multiply (or a sum step) each.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_M_VEL,
		ST_W_VEL,
		ST_M_DAMP,
		ST_W_DAMP,
		ST_M_STIF,
		ST_W_STIF,
		ST_M_DD,
		ST_W_DD,
		ST_M_V,
		ST_W_V,
		ST_M_A,
		ST_W_A,
		ST_M_SA,
		ST_W_SA,
		ST_OUT
	} nsp_state_t;

	// Multiplier request and status between sequencer and multiplier.
	typedef struct packed {
		logic start;
	} nsp_mul_ctl_t;

	typedef struct packed {
		logic done;
	} nsp_mul_sts_t;

endpackage

>>> rtl/core/nsp_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsp_mul: digit-serial fixed-point multiplier
// Signed magnitude shift-and-add, one digit of the multiplier per cycle,
// then rounding (ties away from zero) and saturation to the word range.
// ----------------------------------------------------------------------------
module nsp_mul import nsp_pkg::*; #(
	parameter int WORD_BITS = DEF_WORD_BITS,
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  nsp_mul_ctl_t                ctl,
	input  logic signed [WORD_BITS-1:0] a,
	input  logic signed [WORD_BITS-1:0] b,
	output nsp_mul_sts_t                sts,
	output logic signed [WORD_BITS-1:0] p
);

	localparam int STEPS    = (WORD_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
	localparam int MB       = STEPS * DIGIT_BITS;
	localparam int PB       = WORD_BITS + MB;
	localparam int CNT_BITS = $clog2(STEPS + 2);
	localparam logic [CNT_BITS-1:0] LAST = CNT_BITS'(STEPS);

	logic [WORD_BITS-1:0]  ma_q;
	logic [MB-1:0]         mb_q;
	logic [PB-1:0]         acc_q;
	logic                  neg_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic                  busy_q;
	logic                  fin_q;
	logic [WORD_BITS-1:0]  mag_a;
	logic [WORD_BITS-1:0]  mag_b;
	logic [WORD_BITS+DIGIT_BITS-1:0] part;
	logic [WORD_BITS+DIGIT_BITS-1:0] sum;
	logic [PB:0]           rnd;
	logic [PB:0]           shr;
	logic [WORD_BITS-1:0]  lim;
	logic [WORD_BITS-1:0]  sat;
	logic signed [WORD_BITS-1:0] res;

	assign mag_a = a[WORD_BITS-1] ? (~a + 1'b1) : a;
	assign mag_b = b[WORD_BITS-1] ? (~b + 1'b1) : b;
	assign part  = ma_q * mb_q[DIGIT_BITS-1:0];
	assign sum   = {{DIGIT_BITS{1'b0}}, acc_q[PB-1:MB]} + part;

	// Product accumulated low digit first: accumulator shifts right a digit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			fin_q  <= 1'b0;
		end else begin
			fin_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST - 1'b1) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			ma_q  <= mag_a;
			mb_q  <= MB'(mag_b);
			neg_q <= a[WORD_BITS-1] ^ b[WORD_BITS-1];
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= {sum, acc_q[MB-1:DIGIT_BITS]};
			mb_q  <= mb_q >> DIGIT_BITS;
		end
	end

	assign rnd = {1'b0, acc_q} + ((PB+1)'(1) << (FRAC_BITS - 1));
	assign shr = rnd >> FRAC_BITS;
	assign lim = neg_q ? (WORD_BITS'(1) << (WORD_BITS - 1))
		: ((WORD_BITS'(1) << (WORD_BITS - 1)) - 1'b1);
	assign sat = (shr > (PB+1)'(lim)) ? lim : shr[WORD_BITS-1:0];
	assign res = neg_q ? (~sat + 1'b1) : sat;

	always_ff @(posedge clk) begin
		if (fin_q) begin
			p <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sts.done <= 1'b0;
		end else begin
			sts.done <= fin_q;
		end
	end

endmodule

>>> rtl/core/newmark_sdof_peak_response_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// newmark_sdof_peak_response_core: oscillator peak-response spectrum core
// Newmark average-acceleration step of a unit-mass damped oscillator per
// ground-acceleration sample, with running peak displacement and pseudo
// spectral acceleration.
//
//   channel  | direction | payload
//   in       | input     | nsp_in_t  (accel_sample, first_sample)
//   out      | output    | nsp_out_t (peak_disp, spectral_accel)
//   cfg      | input     | nsp_cfg_t (register index, data)
//
// One sample takes seven products, in turn, on one digit-serial multiplier,
// between accepting the request and loading the output register.
// Reset clears the state, the peak and all coefficient registers.
// A result waits in the output register until taken; the next request is
// accepted meanwhile, and only its output step holds while the result is there.
// ----------------------------------------------------------------------------
module newmark_sdof_peak_response_core import nsp_pkg::*; #(
	parameter int WORD_BITS = DEF_WORD_BITS,
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  nsp_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output nsp_out_t out_data,
	input  logic     cfg_valid,
	output logic     cfg_ready,
	input  nsp_cfg_t cfg_data
);

	typedef logic signed [WORD_BITS-1:0] word_t;
	localparam word_t W_HI = word_t'((64'(1) << (WORD_BITS - 1)) - 1);
	localparam word_t W_LO = ~W_HI;

	function automatic word_t s_add(input word_t x, input word_t y);
		logic signed [WORD_BITS:0] s;
		s = {x[WORD_BITS-1], x} + {y[WORD_BITS-1], y};
		if (s[WORD_BITS] != s[WORD_BITS-1]) begin
			return s[WORD_BITS] ? W_LO : W_HI;
		end
		return s[WORD_BITS-1:0];
	endfunction

	function automatic word_t s_neg(input word_t x);
		return (x == W_LO) ? W_HI : -x;
	endfunction

	function automatic word_t fit(input logic [63:0] v, input int bits);
		logic [63:0] m;
		m = v & ((64'(1) << bits) - 1);
		if (m > 64'(W_HI)) begin
			return W_HI;
		end
		return m[WORD_BITS-1:0];
	endfunction

	function automatic word_t fit_in(input logic signed [IN_BITS-1:0] v);
		logic signed [63:0] e;
		e = 64'(v);
		if (e > 64'(W_HI)) begin
			return W_HI;
		end
		if (e < 64'(W_LO) ) begin
			return W_LO;
		end
		return e[WORD_BITS-1:0];
	endfunction

	function automatic logic [OUT_BITS-1:0] out_clamp(input word_t x);
		logic signed [63:0] e;
		e = 64'(x);
		if (x < 0) begin
			return '0;
		end
		if (e > 64'((64'(1) << OUT_BITS) - 1)) begin
			return '1;
		end
		return e[OUT_BITS-1:0];
	endfunction

	word_t k_q, c_q, ik_q, t2_q, f4_q, sa_q;
	word_t d_q, v_q, a_q, pk_q, f_q, vp_q, ap_q, r_q, dd_q;
	nsp_state_t state_q, state_d;
	nsp_mul_ctl_t mctl;
	nsp_mul_sts_t msts;
	word_t ma, mb, mp, d_new, ad;
	logic out_valid_q;
	logic out_load;
	nsp_out_t out_q;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// The output register is loaded once the previous result has left or is being taken.
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0; c_q <= '0; ik_q <= '0;
			t2_q <= '0; f4_q <= '0; sa_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_data.index)
				REG_STIFFNESS: k_q  <= fit(64'(cfg_data.data), CFG_BITS);
				REG_DAMPING:   c_q  <= fit(64'(cfg_data.data), CFG_BITS);
				REG_INV_K_HAT: ik_q <= fit(64'(cfg_data.data), CFG_BITS);
				REG_TWO_DT:    t2_q <= fit(64'(cfg_data.data), CFG_BITS);
				REG_FOUR_DT2:  f4_q <= fit(64'(cfg_data.data), CFG_BITS);
				REG_SA_SCALE:  sa_q <= fit(64'(cfg_data.data), CFG_BITS);
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_valid && in_ready) state_d = ST_M_VEL;
			ST_M_VEL:  state_d = ST_W_VEL;
			ST_W_VEL:  if (msts.done) state_d = ST_M_DAMP;
			ST_M_DAMP: state_d = ST_W_DAMP;
			ST_W_DAMP: if (msts.done) state_d = ST_M_STIF;
			ST_M_STIF: state_d = ST_W_STIF;
			ST_W_STIF: if (msts.done) state_d = ST_M_DD;
			ST_M_DD:   state_d = ST_W_DD;
			ST_W_DD:   if (msts.done) state_d = ST_M_V;
			ST_M_V:    state_d = ST_W_V;
			ST_W_V:    if (msts.done) state_d = ST_M_A;
			ST_M_A:    state_d = ST_W_A;
			ST_W_A:    if (msts.done) state_d = ST_M_SA;
			ST_M_SA:   state_d = ST_W_SA;
			ST_W_SA:   if (msts.done) state_d = ST_OUT;
			ST_OUT:    if (out_load) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		mctl.start = 1'b0;
		ma = '0;
		mb = '0;
		case (state_q)
			ST_M_VEL:  begin mctl.start = 1'b1; ma = s_add(t2_q, t2_q); mb = v_q; end
			ST_M_DAMP: begin mctl.start = 1'b1; ma = c_q;  mb = vp_q; end
			ST_M_STIF: begin mctl.start = 1'b1; ma = k_q;  mb = d_q; end
			ST_M_DD:   begin mctl.start = 1'b1; ma = r_q;  mb = ik_q; end
			ST_M_V:    begin mctl.start = 1'b1; ma = t2_q; mb = dd_q; end
			ST_M_A:    begin mctl.start = 1'b1; ma = f4_q; mb = dd_q; end
			ST_M_SA:   begin mctl.start = 1'b1; ma = pk_q; mb = sa_q; end
			default:   ;
		endcase
	end

	nsp_mul #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_mul (
		.clk(clk), .arst_n(arst_n), .ctl(mctl), .a(ma), .b(mb), .sts(msts), .p(mp)
	);

	assign d_new = s_add(d_q, mp);
	assign ad    = (d_new < 0) ? s_neg(d_new) : d_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			d_q <= '0; v_q <= '0; a_q <= '0; pk_q <= '0;
			f_q <= '0; vp_q <= '0; ap_q <= '0; r_q <= '0; dd_q <= '0;
			out_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q          <= 1'b1;
				out_q.peak_disp      <= out_clamp(pk_q);
				out_q.spectral_accel <= out_clamp(mp);
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: if (in_valid && in_ready) begin
					f_q <= fit_in(in_data.accel_sample);
					if (in_data.first_sample) begin
						d_q <= '0; v_q <= '0; pk_q <= '0;
						a_q <= fit_in(in_data.accel_sample);
					end
				end
				ST_W_VEL: if (msts.done) begin
					vp_q <= s_neg(v_q);
					ap_q <= s_add(s_neg(mp), s_neg(a_q));
					r_q  <= s_add(f_q, s_neg(s_add(s_neg(mp), s_neg(a_q))));
				end
				ST_W_DAMP: if (msts.done) r_q <= s_add(r_q, s_neg(mp));
				ST_W_STIF: if (msts.done) r_q <= s_add(r_q, s_neg(mp));
				ST_W_DD: if (msts.done) begin
					dd_q <= mp;
					d_q  <= d_new;
					if (ad > pk_q) pk_q <= ad;
				end
				ST_W_V: if (msts.done) v_q <= s_add(vp_q, mp);
				ST_W_A: if (msts.done) a_q <= s_add(ap_q, mp);
				default: ;
			endcase
		end
	end

endmodule

>>> tb/newmark_sdof_peak_response_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// newmark_sdof_peak_response_core_tb: self-checking bench for the peak core
// Feeds ground-acceleration records through the oscillator core over several
// coefficient sets (zero, full scale, random, and real periods). A local
// Newmark integrator predicts peak displacement and spectral acceleration.
// Every result is checked in order, with random stalls on both sides.
// ----------------------------------------------------------------------------
module newmark_sdof_peak_response_core_tb;
	import nsp_pkg::*;

	localparam logic [IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [IDX_BITS-1:0] REG_SPARE_HI = 3'd7;
	localparam longint W_HI = (64'sd1 <<< 47) - 1;
	localparam longint W_LO = -W_HI - 1;
	localparam int CYCLE_LIMIT = 2000000;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     in_valid = 1'b0;
	logic     in_ready;
	nsp_in_t  in_data = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	nsp_out_t out_data;
	logic     cfg_valid = 1'b0;
	logic     cfg_ready;
	nsp_cfg_t cfg_data = '0;

	newmark_sdof_peak_response_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	nsp_in_t  sample_q[$];
	nsp_cfg_t write_q[$];
	nsp_out_t peak_q[$];
	int n_queued = 0, n_taken = 0, n_checked = 0;
	int n_writes = 0, n_written = 0;
	int n_errors = 0;
	int cycles = 0;
	logic calm;

	// Local copy of the coefficients and oscillator state.
	longint k_stiff, k_damp, k_inv_hat, k_two_dt, k_four_dt2, k_sa;
	longint osc_disp, osc_vel, osc_acc, osc_peak;

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic longint sat_word(longint x);
		if (x > W_HI) return W_HI;
		if (x < W_LO) return W_LO;
		return x;
	endfunction

	function automatic longint qadd(longint a, longint b);
		return sat_word(a + b);
	endfunction

	function automatic longint qneg(longint a);
		return (a == W_LO) ? W_HI : -a;
	endfunction

	// Rounded Q24.24 product, ties away from zero, saturated to the word.
	function automatic longint qmul(longint a, longint b);
		logic [127:0] ua, ub, p, lim;
		logic neg;
		ua = (a < 0) ? 128'(-a) : 128'(a);
		ub = (b < 0) ? 128'(-b) : 128'(b);
		neg = (a < 0) != (b < 0);
		p = ((ua * ub) + (128'd1 << 23)) >> 24;
		lim = neg ? (128'd1 << 47) : 128'(W_HI);
		if (p > lim) p = lim;
		return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
	endfunction

	function automatic nsp_out_t step_oscillator(nsp_in_t item);
		longint force_in, four_dt, vp, ap, r, dd, ad, sa;
		nsp_out_t res;
		force_in = {{16{item.accel_sample[IN_BITS-1]}}, item.accel_sample};
		if (item.first_sample) begin
			osc_disp = 0;
			osc_vel = 0;
			osc_acc = force_in;
			osc_peak = 0;
		end
		four_dt = qadd(k_two_dt, k_two_dt);
		vp = qneg(osc_vel);
		ap = qadd(qneg(qmul(four_dt, osc_vel)), qneg(osc_acc));
		r = qadd(force_in, qneg(ap));
		r = qadd(r, qneg(qmul(k_damp, vp)));
		r = qadd(r, qneg(qmul(k_stiff, osc_disp)));
		dd = qmul(r, k_inv_hat);
		osc_disp = qadd(osc_disp, dd);
		osc_vel = qadd(vp, qmul(k_two_dt, dd));
		osc_acc = qadd(ap, qmul(k_four_dt2, dd));
		ad = (osc_disp < 0) ? qneg(osc_disp) : osc_disp;
		if (ad > osc_peak) osc_peak = ad;
		sa = qmul(osc_peak, k_sa);
		res.peak_disp = (osc_peak < 0) ? '0 : osc_peak[OUT_BITS-1:0];
		res.spectral_accel = (sa < 0) ? '0 : sa[OUT_BITS-1:0];
		return res;
	endfunction

	// No idling while the middle of the run goes through.
	assign calm = (n_taken >= 700) && (n_taken < 1000);

	// Sample driver; predicts each request as it is accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				peak_q.push_back(step_oscillator(in_data));
				n_taken <= n_taken + 1;
			end
			if (!in_valid || in_ready) begin
				if (sample_q.size() > 0 && (calm || $urandom_range(99) >= 12)) begin
					in_valid <= 1'b1;
					in_data <= sample_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Register write driver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_valid <= 1'b0;
			k_stiff = 0; k_damp = 0; k_inv_hat = 0;
			k_two_dt = 0; k_four_dt2 = 0; k_sa = 0;
			osc_disp = 0; osc_vel = 0; osc_acc = 0; osc_peak = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_data.index)
					REG_STIFFNESS: k_stiff = {17'd0, cfg_data.data};
					REG_DAMPING:   k_damp = {17'd0, cfg_data.data};
					REG_INV_K_HAT: k_inv_hat = {17'd0, cfg_data.data};
					REG_TWO_DT:    k_two_dt = {17'd0, cfg_data.data};
					REG_FOUR_DT2:  k_four_dt2 = {17'd0, cfg_data.data};
					REG_SA_SCALE:  k_sa = {17'd0, cfg_data.data};
					default: ;
				endcase
				n_written <= n_written + 1;
			end
			if (!cfg_valid || cfg_ready) begin
				if (write_q.size() > 0) begin
					cfg_valid <= 1'b1;
					cfg_data <= write_q.pop_front();
				end else begin
					cfg_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and receiver stalls.
	always @(posedge clk or negedge arst_n) begin
		nsp_out_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= calm || ($urandom_range(99) >= 12);
			if (out_valid && out_ready) begin
				if (peak_q.size() == 0) begin
					$error("unexpected result: peak_disp %0d spectral_accel %0d",
						out_data.peak_disp, out_data.spectral_accel);
					n_errors++;
				end else begin
					want = peak_q.pop_front();
					if (out_data.peak_disp !== want.peak_disp) begin
						$error("peak_disp: expected %0d, got %0d",
							want.peak_disp, out_data.peak_disp);
						n_errors++;
					end
					if (out_data.spectral_accel !== want.spectral_accel) begin
						$error("spectral_accel: expected %0d, got %0d",
							want.spectral_accel, out_data.spectral_accel);
						n_errors++;
					end
					n_checked <= n_checked + 1;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic put_sample(logic [IN_BITS-1:0] a, logic first);
		sample_q.push_back('{accel_sample: a, first_sample: first});
		n_queued++;
	endtask

	task automatic put_write(logic [IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
		write_q.push_back('{index: idx, data: val});
		n_writes++;
	endtask

	// Lets the core drain and the register writes land before the next phase.
	task automatic settle();
		wait (n_taken == n_queued && n_checked == n_taken && n_written == n_writes);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [CFG_BITS-1:0] to_q(real x);
		return CFG_BITS'(longint'(x * 16777216.0));
	endfunction

	// Host-side coefficients for one period, 5% damping, dt 0.02 s.
	task automatic set_period(int n);
		real period, w, dt, c, khat;
		period = 0.04 + n * 0.02;
		dt = 0.02;
		w = 2.0 * 3.14159265358979 / period;
		c = 2.0 * w * 0.05;
		khat = w * w + 2.0 * c / dt + 4.0 / (dt * dt);
		put_write(REG_STIFFNESS, to_q(w * w));
		put_write(REG_DAMPING, to_q(c));
		put_write(REG_INV_K_HAT, to_q(1.0 / khat));
		put_write(REG_TWO_DT, to_q(2.0 / dt));
		put_write(REG_FOUR_DT2, to_q(4.0 / (dt * dt)));
		put_write(REG_SA_SCALE, to_q(w * w / 9.81));
	endtask

	function automatic logic [47:0] rand48();
		return {16'($urandom), 32'($urandom)};
	endfunction

	initial begin
		logic [IN_BITS-1:0] hi_s, lo_s;
		longint a;
		int rec_left, n;
		hi_s = {1'b0, {47{1'b1}}};
		lo_s = {1'b1, 47'd0};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Coefficients still at reset: displacement and peak never move.
		put_sample(hi_s, 1'b1);
		put_sample(lo_s, 1'b0);
		put_sample('1, 1'b0);
		put_sample('0, 1'b0);
		settle();

		// Full-scale coefficients drive the datapath into saturation.
		put_write(REG_STIFFNESS, '1);
		put_write(REG_DAMPING, '1);
		put_write(REG_INV_K_HAT, '1);
		put_write(REG_TWO_DT, '1);
		put_write(REG_FOUR_DT2, '1);
		put_write(REG_SA_SCALE, '1);
		put_write(REG_SPARE_LO, '0);
		put_write(REG_SPARE_HI, '0);
		settle();
		put_sample(hi_s, 1'b1);
		put_sample(lo_s, 1'b0);
		put_sample(hi_s, 1'b0);
		put_sample(lo_s, 1'b1);
		put_sample('0, 1'b0);
		put_sample('1, 1'b0);
		put_sample(48'd1, 1'b1);
		put_sample(48'd1 << 24, 1'b0);
		settle();

		// Random coefficients with random samples.
		for (int ph = 0; ph < 2; ph++) begin
			for (int r = 0; r < 6; r++)
				put_write(IDX_BITS'(r), CFG_BITS'(rand48()));
			put_write(REG_SPARE_HI, CFG_BITS'(rand48()));
			settle();
			for (int i = 0; i < 60; i++)
				put_sample(rand48(), $urandom_range(9) == 0);
			settle();
		end

		// Real periods with smooth records, some noise and early restarts.
		for (int ph = 0; ph < 14; ph++) begin
			n = (ph == 0) ? 0 : (ph == 1) ? 99 : $urandom_range(99);
			set_period(n);
			settle();
			rec_left = 0;
			a = 0;
			for (int i = 0; i < 120; i++) begin
				if (rec_left == 0) begin
					rec_left = $urandom_range(90, 15);
					a = $signed($urandom_range(1 << 24)) - (1 << 23);
					put_sample(a[47:0], 1'b1);
				end else if ($urandom_range(99) < 8) begin
					put_sample(rand48(), $urandom_range(3) == 0);
				end else begin
					a = a + $signed($urandom_range(1 << 24)) - (1 << 23);
					if (a > (64'sd1 <<< 28)) a = 64'sd1 <<< 28;
					if (a < -(64'sd1 <<< 28)) a = -(64'sd1 <<< 28);
					put_sample(a[47:0], 1'b0);
				end
				rec_left--;
			end
			settle();
		end

		repeat (150) @(posedge clk);
		if (n_errors == 0 && peak_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> newmark_sdof_peak_response_core.f
rtl/core/nsp_pkg.sv
rtl/core/nsp_mul.sv
rtl/core/newmark_sdof_peak_response_core.sv
tb/newmark_sdof_peak_response_core_tb.sv
